[hdl/twist_to_drive_command_assert.svh]
// Assertion macros for the twist to drive command block.
// Define NO_ASSERTIONS to compile them out.
`ifndef TWIST_TO_DRIVE_COMMAND_ASSERT_SVH
`define TWIST_TO_DRIVE_COMMAND_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define T2D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define T2D_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define T2D_ASSERT(label, clk, rst, prop, msg)
`define T2D_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hdl/t2d_pkg.sv]
// Package for the twist to drive command block: types, constants, arctangent table.
// No dependencies.
package t2d_pkg;

   localparam int FRAC_BITS = 12;
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_ODOM = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;
   localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
   localparam logic [1:0] GEAR_FORWARD = 2'd1;
   localparam logic [1:0] GEAR_REVERSE = 2'd2;
   localparam logic [2:0] CSR_MAX_STEER  = 3'd0;
   localparam logic [2:0] CSR_THR_GAIN   = 3'd1;
   localparam logic [2:0] CSR_BRK_GAIN   = 3'd2;
   localparam logic [2:0] CSR_SPEED_TOL  = 3'd3;
   localparam logic [2:0] CSR_DEADBAND   = 3'd4;
   localparam logic [2:0] CSR_THR_FLOOR  = 3'd5;
   localparam logic [2:0] CSR_STOP_BRAKE = 3'd6;
   localparam logic [12:0] FULL_OUT    = 13'd4096;
   localparam logic [12:0] HOLD_BRAKE  = 13'd1229;
   localparam logic [12:0] EXTRA_BRAKE = 13'd819;
   localparam logic [14:0] STEER_ONE   = 15'd16384;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_SQRT  = 8'b00000010,
      ST_PREP  = 8'b00000100,
      ST_ATAN  = 8'b00001000,
      ST_DINIT = 8'b00010000,
      ST_DIV   = 8'b00100000,
      ST_DRIVE = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   typedef struct packed {
      logic load;
      logic sqrt_step;
      logic prep;
      logic atan_step;
      logic div_init;
      logic div_step;
      logic drive;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0: r = 30'd843314857;  5'd1: r = 30'd497837829;
         5'd2: r = 30'd263043836;  5'd3: r = 30'd133525159;
         5'd4: r = 30'd67021687;   5'd5: r = 30'd33543516;
         5'd6: r = 30'd16775851;   5'd7: r = 30'd8388437;
         5'd8: r = 30'd4194283;    5'd9: r = 30'd2097149;
         5'd10: r = 30'd1048576;   5'd11: r = 30'd524288;
         5'd12: r = 30'd262144;    5'd13: r = 30'd131072;
         5'd14: r = 30'd65536;     5'd15: r = 30'd32768;
         5'd16: r = 30'd16384;     5'd17: r = 30'd8192;
         5'd18: r = 30'd4096;      5'd19: r = 30'd2048;
         5'd20: r = 30'd1024;      5'd21: r = 30'd512;
         5'd22: r = 30'd256;       5'd23: r = 30'd128;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

[hdl/t2d_ctrl.sv]
// Controller for the twist to drive command block: sequences sqrt, arctangent,
// division and drive steps. Depends on t2d_pkg.
module t2d_ctrl
   import t2d_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);
   localparam int CW = 5;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(16)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_ATAN;
         end
         ST_ATAN: begin
            cmd.atan_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ANGLE_ITERATIONS)) begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.last) begin
               state_in = ST_DRIVE;
            end
         end
         ST_DRIVE: begin
            cmd.drive = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   `include "twist_to_drive_command_assert.svh"
   `T2D_ASSERT(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `T2D_ASSERT(a_out_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")
   `T2D_ASSERT(a_drive_then_out, clock, reset, cmd.drive |=> rsp_valid, "drive not followed by result")
endmodule

[hdl/t2d_dp.sv]
// Datapath for the twist to drive command block: held state, config registers,
// bit-serial sqrt, CORDIC, restoring divider and drive rules. Depends on t2d_pkg.
module t2d_dp
   import t2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_target_speed,
   input  logic signed [15:0] req_target_yaw_rate,
   input  logic signed [15:0] req_measured_vx,
   input  logic signed [15:0] req_measured_vy,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  cmd_type            cmd,
   output status_type         status,
   output logic               tick_ready,
   output logic signed [15:0] rsp_steer,
   output logic [12:0]        rsp_throttle,
   output logic [12:0]        rsp_brake,
   output logic [1:0]         rsp_gear
);
   localparam longint ONE_F = 64'sd1 <<< FRAC_BITS;
   localparam longint WHEEL_F = (286 * ONE_F + 500) / 1000;
   localparam longint TENTH_F = (ONE_F + 5) / 10;
   localparam longint HUND_F = (ONE_F + 50) / 100;
   localparam int YW = 16 + 16 + 2;
   localparam int XW = 16 + FRAC_BITS + 3;
   localparam int CWD = (YW > XW) ? YW + 2 : XW + 2;
   localparam int DIVW = 30;

   logic [12:0] max_steer_ff, deadband_ff, floor_ff, stop_brake_ff;
   logic [15:0] thr_gain_ff, brk_gain_ff;
   logic [14:0] tol_ff;
   logic signed [15:0] tgt_ff, yaw_ff, vx_ff, vy_ff;
   logic cmd_seen_ff, odom_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_steer_ff <= 13'd2867; thr_gain_ff <= 16'd2048; brk_gain_ff <= 16'd2048;
         tol_ff <= 15'd41; deadband_ff <= 13'd41; floor_ff <= 13'd205;
         stop_brake_ff <= 13'd205;
         tgt_ff <= '0; yaw_ff <= '0; vx_ff <= '0; vy_ff <= '0;
         cmd_seen_ff <= 1'b0; odom_seen_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MAX_STEER:  max_steer_ff  <= csr_data[12:0];
               CSR_THR_GAIN:   thr_gain_ff   <= csr_data;
               CSR_BRK_GAIN:   brk_gain_ff   <= csr_data;
               CSR_SPEED_TOL:  tol_ff        <= csr_data[14:0];
               CSR_DEADBAND:   deadband_ff   <= csr_data[12:0];
               CSR_THR_FLOOR:  floor_ff      <= csr_data[12:0];
               CSR_STOP_BRAKE: stop_brake_ff <= csr_data[12:0];
               default: ;
            endcase
         end
         if (accept && req_kind == KIND_CMD) begin
            tgt_ff <= req_target_speed; yaw_ff <= req_target_yaw_rate;
            cmd_seen_ff <= 1'b1;
         end
         if (accept && req_kind == KIND_ODOM) begin
            vx_ff <= req_measured_vx; vy_ff <= req_measured_vy;
            odom_seen_ff <= 1'b1;
         end
      end
   end

   assign tick_ready = cmd_seen_ff && odom_seen_ff;

   // bit-serial integer square root, one result bit per step
   logic [32:0] sq_n_ff, sq_r_ff, sq_bit_ff;
   logic [32:0] sq_sum;
   logic signed [31:0] vx2, vy2;
   assign vx2 = vx_ff * vx_ff;
   assign vy2 = vy_ff * vy_ff;
   assign sq_sum = sq_r_ff + sq_bit_ff;

   logic [16:0] cur_ff;
   logic [16:0] absd;
   logic [16:0] basis;

   assign absd = tgt_ff[15] ? 17'(-$signed({tgt_ff[15], tgt_ff})) : 17'({1'b0, tgt_ff});
   assign basis = (longint'(cur_ff) > TENTH_F) ? cur_ff :
                  (longint'(absd) > TENTH_F) ? absd : 17'd0;

   function automatic logic signed [CWD-1:0] shr_tz(input logic signed [CWD-1:0] v,
                                                    input logic [4:0] s);
      logic signed [CWD-1:0] m;
      m = v[CWD-1] ? -v : v;
      m = m >>> s;
      return v[CWD-1] ? -m : m;
   endfunction

   // divider: |angle| * 16384 / maxa
   logic [DIVW-1:0] dq_ff, drem_ff;
   logic [4:0] dcnt_ff;
   logic [12:0] maxa;
   logic [DIVW:0] dtrial;
   assign maxa = (max_steer_ff == 13'd0) ? 13'd1 : max_steer_ff;
   assign dtrial = {drem_ff, dq_ff[DIVW-1]} - (DIVW+1)'(maxa);
   assign status.last = (dcnt_ff == 5'(DIVW - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sq_n_ff <= 33'($unsigned(vx2)) + 33'($unsigned(vy2));
         sq_r_ff <= '0;
         sq_bit_ff <= 33'd1 << 32;
      end else if (cmd.sqrt_step) begin
         if (sq_n_ff >= sq_sum) begin
            sq_n_ff <= sq_n_ff - sq_sum;
            sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
         end else begin
            sq_r_ff <= sq_r_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.prep) begin
         cur_ff <= sq_r_ff[16:0];
      end
   end

   // first arctangent step loads the vectors
   logic ld_ff;
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         ld_ff <= 1'b1;
      end else if (cmd.atan_step) begin
         ld_ff <= 1'b0;
      end
   end

   // CORDIC vectoring
   logic signed [CWD-1:0] kx_ff, ky_ff;
   logic signed [FRAC_BITS+3:0] kz_ff;
   logic [4:0] kit_ff;
   logic signed [CWD-1:0] kxs, kys, kx_n, ky_n;
   logic signed [FRAC_BITS+3:0] kz_n, kstep;
   assign kxs = shr_tz(kx_ff, kit_ff);
   assign kys = shr_tz(ky_ff, kit_ff);
   assign kstep = (FRAC_BITS+4)'((31'(atan_q30(kit_ff)) + (31'd1 << (29 - FRAC_BITS)))
                                 >> (30 - FRAC_BITS));
   always_comb begin
      kx_n = kx_ff; ky_n = ky_ff; kz_n = kz_ff;
      if (ky_ff > 0) begin
         kx_n = kx_ff + kys; ky_n = ky_ff - kxs; kz_n = kz_ff + kstep;
      end else if (ky_ff < 0) begin
         kx_n = kx_ff - kys; ky_n = ky_ff + kxs; kz_n = kz_ff - kstep;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         kx_ff  <= CWD'(longint'(sq_r_ff[16:0]));
         ky_ff  <= '0;
         kz_ff  <= '0;
         kit_ff <= '0;
      end else if (cmd.atan_step) begin
         if (ld_ff) begin
            kx_ff <= CWD'(longint'(basis) * ONE_F);
            ky_ff <= (basis != 17'd0) ? CWD'(longint'(yaw_ff) * WHEEL_F) : '0;
            kz_ff <= '0;
            kit_ff <= '0;
         end else begin
            kx_ff <= kx_n; ky_ff <= ky_n; kz_ff <= kz_n;
            kit_ff <= kit_ff + 1'b1;
         end
      end
   end

   logic [FRAC_BITS+3:0] kang;
   logic kneg, kzero;
   assign kneg  = kz_ff[FRAC_BITS+3];
   assign kang  = kneg ? -kz_ff : kz_ff;
   assign kzero = kang < (FRAC_BITS+4)'(deadband_ff);

   logic neg_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dq_ff   <= kzero ? '0 : DIVW'(kang) << 14;
         drem_ff <= '0;
         dcnt_ff <= '0;
         neg_ff  <= kneg && !kzero;
      end else if (cmd.div_step) begin
         if (!dtrial[DIVW]) begin
            drem_ff <= dtrial[DIVW-1:0];
            dq_ff   <= {dq_ff[DIVW-2:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[DIVW-2:0], dq_ff[DIVW-1]};
            dq_ff   <= {dq_ff[DIVW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // drive rules
   logic signed [17:0] cur_s, des_s, err;
   logic [17:0] abserr;
   logic [12:0] thr_c, brk_c;
   logic [1:0] gear_c;
   logic [31:0] thr_prod, brk_prod, pos_prod;
   logic [12:0] thr_sc, brk_sc;
   logic [15:0] mag;
   logic [31:0] q;

   function automatic logic [12:0] clamp_full(input logic [31:0] v);
      return (v > 32'(FULL_OUT)) ? FULL_OUT : v[12:0];
   endfunction

   assign cur_s = 18'($signed({1'b0, cur_ff}));
   assign des_s = 18'(tgt_ff);
   assign err = des_s - cur_s;
   assign abserr = err[17] ? 18'(-err) : 18'(err);
   assign thr_prod = 32'((34'(thr_gain_ff) * 34'(abserr)) >> FRAC_BITS);
   assign brk_prod = 32'((34'(brk_gain_ff) * 34'(abserr)) >> FRAC_BITS);
   assign pos_prod = 32'd0;
   assign thr_sc = clamp_full(thr_prod);
   assign brk_sc = clamp_full(brk_prod + pos_prod);

   always_comb begin
      thr_c = '0; brk_c = '0; gear_c = GEAR_NEUTRAL;
      if (longint'(absd) < HUND_F) begin
         if (longint'(cur_ff) > HUND_F) brk_c = clamp_full(32'(stop_brake_ff));
         else brk_c = HOLD_BRAKE;
      end else if (!tgt_ff[15]) begin
         gear_c = GEAR_FORWARD;
         if (abserr > 18'(tol_ff)) begin
            if (!err[17]) thr_c = thr_sc;
            else brk_c = brk_sc;
         end
      end else if (longint'(cur_ff) > TENTH_F) begin
         brk_c = brk_sc;
      end else begin
         gear_c = GEAR_REVERSE;
         if (abserr > 18'(tol_ff)) begin
            if (err[17]) thr_c = thr_sc;
            else brk_c = brk_sc;
         end
      end
      if (gear_c != GEAR_NEUTRAL && thr_c != 13'd0 && thr_c < floor_ff) thr_c = floor_ff;
      if (thr_c > FULL_OUT) thr_c = FULL_OUT;
   end

   assign q = 32'(dq_ff);
   assign mag = (q > 32'(STEER_ONE)) ? 16'(STEER_ONE) : q[15:0];

   always_ff @(posedge clock) begin
      if (cmd.drive) begin
         rsp_steer    <= neg_ff ? -$signed(mag) : $signed(mag);
         rsp_throttle <= thr_c;
         rsp_brake    <= brk_c;
         rsp_gear     <= gear_c;
      end
   end

   `include "twist_to_drive_command_assert.svh"
   `T2D_ASSERT(a_cur_range, clock, reset, cmd.drive |-> cur_ff < 17'd46341, "speed out of range")
   `T2D_ASSERT(a_seen, clock, reset, cmd.load |-> tick_ready, "tick before state")
   `T2D_ASSERT(a_thr_full, clock, reset, cmd.drive |=> rsp_throttle <= FULL_OUT, "throttle over full")
endmodule

[hdl/twist_to_drive_command.sv]
// Top level of the twist to drive command block.
// Instantiates t2d_ctrl and t2d_dp; depends on t2d_pkg.
//
// Usage:
//   req_ channel carries command updates, odometry updates and ticks.
//   Command and odometry items are taken while idle and give no result.
//   A tick after both kinds were seen starts a computation: 17 sqrt steps,
//   a prepare step, ANGLE_ITERATIONS+1 CORDIC steps, a divider load step,
//   30 divider steps and one drive step; the result then waits on rsp_ until
//   taken. The controller handles one tick at a time, so req_ready is low
//   from the tick until the cycle after its result is taken.
//   Ticks before both kinds were seen and kind 3 are taken and dropped.
//   Reset clears held values, seen flags and loads register defaults;
//   req_ready stays low during reset.
//   csr_ writes take effect at once; write only while idle.
//   A stalled receiver holds the result and the block.
module twist_to_drive_command
   import t2d_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_target_speed,
   input  logic signed [15:0] req_target_yaw_rate,
   input  logic signed [15:0] req_measured_vx,
   input  logic signed [15:0] req_measured_vy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_steer,
   output logic [12:0]        rsp_throttle,
   output logic [12:0]        rsp_brake,
   output logic [1:0]         rsp_gear,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   cmd_type    cmd;
   status_type status;
   logic busy, accept, tick_ready, start;

   assign req_ready = !busy && !reset;
   assign accept = req_valid && req_ready;
   assign start = accept && req_kind == KIND_TICK && tick_ready;

   t2d_ctrl #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   t2d_dp u_dp (
      .clock(clock), .reset(reset), .accept(accept), .req_kind(req_kind),
      .req_target_speed(req_target_speed), .req_target_yaw_rate(req_target_yaw_rate),
      .req_measured_vx(req_measured_vx), .req_measured_vy(req_measured_vy),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .status(status), .tick_ready(tick_ready),
      .rsp_steer(rsp_steer), .rsp_throttle(rsp_throttle),
      .rsp_brake(rsp_brake), .rsp_gear(rsp_gear)
   );
endmodule

[tb/twist_to_drive_command_tb.sv]
// Self-checking bench for twist_to_drive_command: drives command, odometry, tick and kind 3 items
// and compares every drive command with an in-bench fixed-point predictor.
// Depends on t2d_pkg and the twist_to_drive_command RTL.
module twist_to_drive_command_tb;
   import t2d_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [2:0] CSR_SPARE = 3'd7;
   localparam longint WHEELBASE = 1171;
   localparam longint TENTH = 410;
   localparam longint HUNDREDTH = 41;
   localparam int SETTLE = 100;

   typedef struct packed {
      logic signed [15:0] steer;
      logic [12:0] throttle;
      logic [12:0] brake;
      logic [1:0] gear;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = KIND_CMD;
   logic signed [15:0] req_target_speed = '0;
   logic signed [15:0] req_target_yaw_rate = '0;
   logic signed [15:0] req_measured_vx = '0;
   logic signed [15:0] req_measured_vy = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_steer;
   logic [12:0] rsp_throttle;
   logic [12:0] rsp_brake;
   logic [1:0] rsp_gear;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = CSR_MAX_STEER;
   logic [15:0] csr_data = '0;

   drive_type expected_cmds[$];
   int mismatches = 0;
   bit quiet = 1'b0;
   int rsp_stall = 0;

   longint max_angle, thr_gain, brk_gain, speed_tol, deadband, thr_floor, stop_brk;
   longint hold_speed, hold_yaw, hold_vx, hold_vy;
   bit cmd_seen, odom_seen;

   twist_to_drive_command dut (.*);

   always #2 clock = ~clock;

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic longint shift_tz(longint v, int s);
      return v < 0 ? -((-v) >>> s) : v >>> s;
   endfunction

   function automatic longint gain_scale(longint g, longint m);
      longint v;
      v = (g * m) >>> 12;
      return v > 4096 ? 4096 : v;
   endfunction

   function automatic longint apply_floor(longint t);
      if (t > 0 && t < thr_floor) t = thr_floor;
      return t > 4096 ? 4096 : t;
   endfunction

   function automatic void reset_model();
      max_angle = 2867; thr_gain = 2048; brk_gain = 2048; speed_tol = 41;
      deadband = 41; thr_floor = 205; stop_brk = 205;
      hold_speed = 0; hold_yaw = 0; hold_vx = 0; hold_vy = 0;
      cmd_seen = 0; odom_seen = 0;
   endfunction

   function automatic void model_csr(logic [2:0] idx, logic [15:0] val);
      case (idx)
         CSR_MAX_STEER:  max_angle = val[12:0];
         CSR_THR_GAIN:   thr_gain = val;
         CSR_BRK_GAIN:   brk_gain = val;
         CSR_SPEED_TOL:  speed_tol = val[14:0];
         CSR_DEADBAND:   deadband = val[12:0];
         CSR_THR_FLOOR:  thr_floor = val[12:0];
         CSR_STOP_BRAKE: stop_brk = val[12:0];
         default: ;
      endcase
   endfunction

   function automatic void predict_drive(logic [1:0] kind, logic signed [15:0] ts,
                                         logic signed [15:0] yaw, logic signed [15:0] vx,
                                         logic signed [15:0] vy);
      longint n, r, b, cur, des, absd, basis, y, x, z, a, xs, ys, angle, maxa, mag;
      longint err, abserr, thr, brk;
      logic [1:0] gear;
      drive_type d;
      if (kind == KIND_CMD) begin
         hold_speed = ts; hold_yaw = yaw; cmd_seen = 1;
         return;
      end
      if (kind == KIND_ODOM) begin
         hold_vx = vx; hold_vy = vy; odom_seen = 1;
         return;
      end
      if (kind != KIND_TICK || !cmd_seen || !odom_seen) return;
      n = hold_vx * hold_vx + hold_vy * hold_vy;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else r = r >>> 1;
         b = b >>> 2;
      end
      cur = r;
      des = hold_speed;
      absd = des < 0 ? -des : des;
      basis = 0;
      angle = 0;
      if (cur > TENTH) basis = cur;
      else if (absd > TENTH) basis = absd;
      y = hold_yaw * WHEELBASE;
      if (basis > 0 && y != 0) begin
         x = basis * 4096;
         z = 0;
         for (int i = 0; i < 16; i++) begin
            a = (longint'(atan_q30(5'(i))) + (64'sd1 <<< 17)) >>> 18;
            xs = shift_tz(x, i);
            ys = shift_tz(y, i);
            if (y > 0) begin
               x = x + ys; y = y - xs; z = z + a;
            end else if (y < 0) begin
               x = x - ys; y = y + xs; z = z - a;
            end
         end
         angle = z;
      end
      if ((angle < 0 ? -angle : angle) < deadband) angle = 0;
      maxa = max_angle == 0 ? 1 : max_angle;
      mag = (angle < 0 ? -angle : angle) * 16384 / maxa;
      if (mag > 16384) mag = 16384;
      d.steer = 16'(angle < 0 ? -mag : mag);
      err = des - cur;
      abserr = err < 0 ? -err : err;
      thr = 0;
      brk = 0;
      if (absd < HUNDREDTH) begin
         brk = cur > HUNDREDTH ? (stop_brk > 4096 ? 4096 : stop_brk) : 1229;
         gear = GEAR_NEUTRAL;
      end else if (des > 0) begin
         gear = GEAR_FORWARD;
         if (abserr > speed_tol) begin
            if (err > 0) thr = gain_scale(thr_gain, abserr);
            else brk = gain_scale(brk_gain, abserr);
         end
         thr = apply_floor(thr);
      end else if (cur > TENTH) begin
         brk = gain_scale(brk_gain, abserr);
         gear = GEAR_NEUTRAL;
      end else begin
         gear = GEAR_REVERSE;
         if (abserr > speed_tol) begin
            if (err < 0) thr = gain_scale(thr_gain, abserr);
            else brk = gain_scale(brk_gain, abserr);
         end
         thr = apply_floor(thr);
      end
      d.throttle = 13'(thr);
      d.brake = 13'(brk);
      d.gear = gear;
      expected_cmds.push_back(d);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH %s: got %0d, want %0d at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      drive_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cmds.size() == 0) report_mismatch("unexpected item", 0, 0);
            else begin
               w = expected_cmds.pop_front();
               if (rsp_steer !== w.steer) report_mismatch("steer", rsp_steer, w.steer);
               if (rsp_throttle !== w.throttle)
                  report_mismatch("throttle", rsp_throttle, w.throttle);
               if (rsp_brake !== w.brake) report_mismatch("brake", rsp_brake, w.brake);
               if (rsp_gear !== w.gear) report_mismatch("gear", rsp_gear, w.gear);
            end
            rsp_stall = draw_wait();
         end else if (rsp_stall > 0) rsp_stall--;
         rsp_ready <= (rsp_stall == 0);
      end
   end

   task automatic send_item(logic [1:0] kind, logic signed [15:0] ts, logic signed [15:0] yaw,
                            logic signed [15:0] vx, logic signed [15:0] vy);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_target_speed <= ts;
      req_target_yaw_rate <= yaw;
      req_measured_vx <= vx;
      req_measured_vy <= vy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_drive(kind, ts, yaw, vx, vy);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] vals[7]);
      drain();
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= (i == 7) ? CSR_SPARE : 3'(i);
         csr_data <= (i == 7) ? 16'hFFFF : vals[i];
         @(posedge clock);
         model_csr((i == 7) ? CSR_SPARE : 3'(i), (i == 7) ? 16'hFFFF : vals[i]);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_speed();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 1200) - 600);
         2: return 16'($urandom_range(0, 120) - 60);
         default: return 16'($urandom_range(0, 9000) - 4500);
      endcase
   endfunction

   task automatic test_unseen_and_spare();
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_SPARE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_item(KIND_CMD, 4096, 1000, 0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_ODOM, 0, 0, 2048, 0);
      send_item(KIND_TICK, 0, 0, 0, 0);
   endtask

   task automatic test_directed_branches();
      send_item(KIND_CMD, 16'sh7FFF, -16'sh8000, 0, 0);
      send_item(KIND_ODOM, 0, 0, -16'sh8000, -16'sh8000);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_CMD, -16'sh8000, 16'sh7FFF, 0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_ODOM, 0, 0, 0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_CMD, 20, 0, 0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_ODOM, 0, 0, 300, -200);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_CMD, 100, 2000, 0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_CMD, -3000, -500, 0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0);
      send_item(KIND_ODOM, 0, 0, -8000, 100);
      send_item(KIND_TICK, 0, 0, 0, 0);
   endtask

   task automatic random_items(int count);
      for (int i = 0; i < count; i += 3) begin
         if ($urandom_range(0, 99) < 15) begin
            send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
         end else begin
            send_item(KIND_CMD, rand_speed(), rand_speed(), 0, 0);
            send_item(KIND_ODOM, 0, 0, rand_speed(), rand_speed());
            send_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end
         if (i % 60 == 0) quiet = !quiet;
      end
   endtask

   task automatic test_register_settings();
      logic [15:0] v[7];
      v = '{1, 0, 0, 0, 0, 0, 0};
      write_regs(v);
      random_items(60);
      v = '{6434, 16'hFFFF, 16'hFFFF, 16'h7FFF, 6434, 4096, 4096};
      write_regs(v);
      random_items(60);
      v = '{0, 16'hFFFF, 16'hFFFF, 0, 0, 16'h1FFF, 16'h1FFF};
      write_regs(v);
      random_items(60);
      for (int k = 0; k < 4; k++) begin
         v = '{16'($urandom_range(1, 6434)), 16'($urandom), 16'($urandom),
               16'($urandom_range(0, 400)), 16'($urandom_range(0, 600)),
               16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096))};
         write_regs(v);
         random_items(100);
      end
   endtask

   initial begin
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unseen_and_spare();
      test_directed_branches();
      random_items(30);
      test_register_settings();
      drain();
      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
